@@ rtl/core/jtlb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jtlb_pkg
// Types and constants shared by the joint TLB read, write and probe unit.
// ----------------------------------------------------------------------------
package jtlb_pkg;

  typedef logic [1:0] func_t;

  localparam func_t FN_READ  = 2'd0;
  localparam func_t FN_WRITE = 2'd1;
  localparam func_t FN_PROBE = 2'd2;

  localparam logic [31:0] HI_RSVD = 32'h0000_1f00;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] hi;
    logic [31:0] lo0;
    logic [31:0] lo1;
    logic        glob;
  } tlb_entry_t;

  // VPN2 (hi 31:13) compare, ignoring bits selected by PageMask 24:13,
  // ASID (hi 7:0) compare unless global.
  function automatic logic entry_match(tlb_entry_t e, logic [31:0] key);
    logic [18:0] diff;
    logic [18:0] care;
    logic        asid_eq;
    diff    = e.hi[31:13] ^ key[31:13];
    care    = ~{7'd0, e.mask[24:13]};
    asid_eq = (e.hi[7:0] == key[7:0]);
    return ((diff & care) == 19'd0) && (e.glob || asid_eq);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/joint_tlb_read_write_probe_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// joint_tlb_read_write_probe_unit
// Joint TLB with read, write and probe operations on a single-port store.
// ----------------------------------------------------------------------------
// One operation is handled at a time. A probe steps through the store one
// entry per cycle over its single read port and stops at the first match.
// Results wait in an output register, so a new item can be taken while the
// previous result is still stalled. Entries start as zero through per-entry
// valid bits; there is no clearing pass after reset.
module joint_tlb_read_write_probe_unit #(
  parameter int ENTRIES = 48
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire jtlb_pkg::func_t in_func,
  input  wire  [5:0]          in_index,
  input  wire  [31:0]         in_page_mask,
  input  wire  [31:0]         in_entry_hi,
  input  wire  [31:0]         in_entry_lo0,
  input  wire  [31:0]         in_entry_lo1,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [31:0]         out_read_page_mask,
  output logic [31:0]         out_read_entry_hi,
  output logic [31:0]         out_read_entry_lo0,
  output logic [31:0]         out_read_entry_lo1,
  output logic [5:0]          out_probe_index,
  output logic                out_probe_miss
);
  import jtlb_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [6:0]    ENT7 = 7'(ENTRIES);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_PR   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  tlb_entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  tlb_entry_t mem_q_r;
  logic       mem_vq_r;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic          rng_r, rng_nxt;
  logic [AW-1:0] rd_addr;
  logic          in_acc, in_rng, slot_free;
  tlb_entry_t    ent;
  logic          hit;
  logic [31:0]   in_entry_hi_r;

  logic [31:0] res_pm_r, res_hi_r, res_lo0_r, res_lo1_r;
  logic [31:0] res_pm_nxt, res_hi_nxt, res_lo0_nxt, res_lo1_nxt;
  logic [5:0]  res_idx_r, res_idx_nxt;
  logic        res_miss_r, res_miss_nxt;

  logic        out_valid_r;
  logic [31:0] out_pm_r, out_hi_r, out_lo0_r, out_lo1_r;
  logic [5:0]  out_idx_r;
  logic        out_miss_r;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_rng    = ({1'b0, in_index} < ENT7);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_addr = (in_func == FN_PROBE) ? '0 : in_index[AW-1:0];
      S_PR:    rd_addr = (cur_r == LAST) ? cur_r : cur_r + AW'(1);
      default: rd_addr = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_func == FN_WRITE && in_rng) begin
      mem[in_index[AW-1:0]] <= '{mask: in_page_mask, hi: in_entry_hi,
                                 lo0: in_entry_lo0, lo1: in_entry_lo1,
                                 glob: in_entry_lo0[0] & in_entry_lo1[0]};
    end
    mem_q_r  <= mem[rd_addr];
    mem_vq_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (in_acc && in_func == FN_WRITE && in_rng) begin
      vld_r[in_index[AW-1:0]] <= 1'b1;
    end
  end

  assign ent = mem_vq_r ? mem_q_r : '0;
  assign hit = entry_match(ent, in_entry_hi_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_entry_hi_r <= in_entry_hi;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    rng_nxt      = rng_r;
    res_pm_nxt   = res_pm_r;
    res_hi_nxt   = res_hi_r;
    res_lo0_nxt  = res_lo0_r;
    res_lo1_nxt  = res_lo1_r;
    res_idx_nxt  = res_idx_r;
    res_miss_nxt = res_miss_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_pm_nxt   = '0;
          res_hi_nxt   = '0;
          res_lo0_nxt  = '0;
          res_lo1_nxt  = '0;
          res_idx_nxt  = '0;
          res_miss_nxt = 1'b0;
          rng_nxt      = in_rng;
          cur_nxt      = rd_addr;
          priority if (in_func == FN_READ) begin
            state_nxt = S_RD;
          end else if (in_func == FN_PROBE) begin
            state_nxt = S_PR;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RD: begin
        if (rng_r) begin
          res_pm_nxt  = ent.mask;
          res_hi_nxt  = ent.hi & ~(ent.mask | HI_RSVD);
          res_lo0_nxt = {ent.lo0[31:1], ent.glob};
          res_lo1_nxt = {ent.lo1[31:1], ent.glob};
        end
        state_nxt = S_OUT;
      end
      S_PR: begin
        priority if (hit) begin
          res_idx_nxt = 6'(cur_r);
          state_nxt   = S_OUT;
        end else if (cur_r == LAST) begin
          res_miss_nxt = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cur_nxt = cur_r + AW'(1);
        end
      end
      default: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      rng_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      rng_r   <= rng_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_pm_r   <= res_pm_nxt;
    res_hi_r   <= res_hi_nxt;
    res_lo0_r  <= res_lo0_nxt;
    res_lo1_r  <= res_lo1_nxt;
    res_idx_r  <= res_idx_nxt;
    res_miss_r <= res_miss_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && slot_free) begin
      out_pm_r   <= res_pm_r;
      out_hi_r   <= res_hi_r;
      out_lo0_r  <= res_lo0_r;
      out_lo1_r  <= res_lo1_r;
      out_idx_r  <= res_idx_r;
      out_miss_r <= res_miss_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_page_mask = out_pm_r;
  assign out_read_entry_hi  = out_hi_r;
  assign out_read_entry_lo0 = out_lo0_r;
  assign out_read_entry_lo1 = out_lo1_r;
  assign out_probe_index    = out_idx_r;
  assign out_probe_miss     = out_miss_r;

  // written entry becomes valid
  a_wr_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_func == FN_WRITE && in_rng |=> vld_r[$past(in_index[AW-1:0])])
    else $error("written entry not marked valid");

  // probe sweep never passes the last entry
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PR |-> ({1'b0, 6'(cur_r)} < ENT7))
    else $error("probe sweep out of range");

  // a pending result is handed over once the output slot is free
  a_handover: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && slot_free |=> out_valid_r && state_r == S_IDLE)
    else $error("result not handed to output");

  // a miss always reports index zero
  a_miss_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_miss_r |-> out_idx_r == 6'd0)
    else $error("probe miss with non-zero index");

endmodule
`default_nettype wire
